/* src/ctt_pkg.sv */
// Shared types and constants for the terminal byte tokenizer.
package ctt_pkg;

  localparam int MAX_TOKEN_BYTES    = 8;
  localparam int PARAM_BUFFER_CHARS = 7;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SUB    = 8'h1A;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_FF     = 8'hFF;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;

  // halfwidth katakana range, bytes in stream order
  localparam logic [23:0] HW_KANA_LO = 24'hEFBDB1;
  localparam logic [23:0] HW_KANA_HI = 24'hEFBE9F;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_UTF8,
    MODE_ESC,
    MODE_CSI
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [63:0] acc;
    logic [3:0]  count;
    logic [2:0]  needed;
    logic [7:0]  pval;
    logic [2:0]  pchars;
    logic        pstop;
  } state_t;

  localparam state_t STATE_IDLE = state_t'{MODE_IDLE, 64'd0, 4'd0, 3'd0, 8'd0, 3'd0, 1'b0};

  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  nbytes;
    logic [1:0]  width;
  } token_t;

endpackage

/* src/ctt_step.sv */
// Next-state and token logic for one input byte.
module ctt_step
  import ctt_pkg::*;
(
  input  state_t     st,
  input  logic [7:0] in_byte,
  output state_t     st_next,
  output logic       emit,
  output token_t     tok
);

  function automatic logic [63:0] put_byte(logic [63:0] acc, logic [3:0] cnt, logic [7:0] b);
    logic [63:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (cnt == 4'(i)) r[8*i +: 8] = b;
    end
    return r;
  endfunction

  logic [63:0] a;
  logic [3:0]  c;
  logic [2:0]  need;
  logic [23:0] be;
  logic        is_letter;
  logic        is_digit;
  logic        has_room;

  always_comb begin
    st_next   = st;
    emit      = 1'b0;
    tok       = '0;
    a         = st.acc;
    c         = st.count;
    need      = st.needed;
    be        = '0;
    is_letter = ((in_byte >= CH_LC_A) && (in_byte <= CH_LC_Z)) ||
                ((in_byte >= CH_UC_A) && (in_byte <= CH_UC_Z));
    is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    has_room  = st.count < 4'(MAX_TOKEN_BYTES);

    unique case (st.mode)
      MODE_IDLE: begin
        if (in_byte == CH_NUL || in_byte == CH_DEL) begin
          st_next = st;
        end else if (in_byte == CH_ESC) begin
          st_next.acc   = {56'd0, CH_ESC};
          st_next.count = 4'd1;
          st_next.mode  = MODE_ESC;
        end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110 ||
                     in_byte[7:3] == 5'b11110) begin
          // multi-byte lead: count continuation bytes
          if (in_byte[7:5] == 3'b110)       need = 3'd1;
          else if (in_byte[7:4] == 4'b1110) need = 3'd2;
          else                              need = 3'd3;
          st_next.acc    = {56'd0, in_byte};
          st_next.count  = 4'd1;
          st_next.needed = need;
          st_next.mode   = MODE_UTF8;
        end else begin
          emit    = 1'b1;
          tok     = '{value: {56'd0, in_byte}, nbytes: 4'd1, width: 2'd1};
          st_next = STATE_IDLE;
        end
      end

      MODE_UTF8: begin
        if (in_byte != CH_NUL) begin
          if (has_room) begin
            a = put_byte(st.acc, st.count, in_byte);
            c = st.count + 4'd1;
          end
          if (need != 3'd0) need = need - 3'd1;
        end
        if (in_byte == CH_NUL || need == 3'd0) begin
          be      = {a[7:0], a[15:8], a[23:16]};
          emit    = 1'b1;
          tok.value  = a;
          tok.nbytes = c;
          if (c <= 4'd1) tok.width = 2'd1;
          else if (c == 4'd3 && be >= HW_KANA_LO && be <= HW_KANA_HI) tok.width = 2'd1;
          else tok.width = 2'd2;
          st_next = STATE_IDLE;
        end else begin
          st_next.acc    = a;
          st_next.count  = c;
          st_next.needed = need;
        end
      end

      MODE_ESC: begin
        if (in_byte == CH_NUL || in_byte == CH_SUB || in_byte == CH_FF) begin
          emit    = 1'b1;
          tok     = '{value: {56'd0, CH_ESC}, nbytes: 4'd1, width: 2'd0};
          st_next = STATE_IDLE;
        end else if (in_byte == CH_LBRACK) begin
          st_next        = STATE_IDLE;
          st_next.acc    = {48'd0, CH_LBRACK, CH_ESC};
          st_next.count  = 4'd2;
          st_next.mode   = MODE_CSI;
        end else begin
          emit    = 1'b1;
          tok     = '{value: {48'd0, in_byte, CH_ESC}, nbytes: 4'd2, width: 2'd0};
          st_next = STATE_IDLE;
        end
      end

      MODE_CSI: begin
        if (in_byte == CH_NUL) begin
          emit    = 1'b1;
          tok     = '{value: st.acc, nbytes: st.count, width: 2'd0};
          st_next = STATE_IDLE;
        end else if (in_byte == CH_SEMI || is_letter) begin
          // close the pending parameter, then the final letter if any
          if (st.pchars != 3'd0 && has_room) begin
            a = put_byte(a, c, st.pval);
            c = c + 4'd1;
          end
          if (is_letter && c < 4'(MAX_TOKEN_BYTES)) begin
            a = put_byte(a, c, in_byte);
            c = c + 4'd1;
          end
          if (is_letter || c >= 4'(MAX_TOKEN_BYTES)) begin
            emit    = 1'b1;
            tok     = '{value: a, nbytes: c, width: 2'd0};
            st_next = STATE_IDLE;
          end else begin
            st_next.acc    = a;
            st_next.count  = c;
            st_next.pval   = 8'd0;
            st_next.pchars = 3'd0;
            st_next.pstop  = 1'b0;
          end
        end else if (st.pchars < 3'(PARAM_BUFFER_CHARS)) begin
          st_next.pchars = st.pchars + 3'd1;
          if (!st.pstop && is_digit) begin
            st_next.pval = {st.pval[4:0], 3'd0} + {st.pval[6:0], 1'b0} + (in_byte - CH_ZERO);
          end else begin
            st_next.pstop = 1'b1;
          end
        end
      end
    endcase
  end

endmodule

/* src/ctt_out_buf.sv */
// Result register between the step logic and the output channel.
module ctt_out_buf
  import ctt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  token_t      tok,
  output logic        buf_free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] token_value,
  output logic [3:0]  token_bytes,
  output logic [1:0]  display_width
);

  token_t held;

  assign buf_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= tok;
    end
  end

  assign token_value   = held.value;
  assign token_bytes   = held.nbytes;
  assign display_width = held.width;

endmodule

/* src/terminal_char_tokenizer_top.sv */
// Top level of the terminal byte tokenizer: parser state and result register.
//
//  channel  dir  handshake              payload
//  input    in   in_valid / in_ready    in_byte
//  output   out  out_valid / out_ready  token_value, token_bytes, display_width
//
// One byte is taken per cycle while in_ready is high; the parser state updates in that same cycle.
// A finished token appears on the output in the cycle after its last byte is taken.
// in_ready drops only while a token sits in the result register and out_ready
// is low; the result register is the single stall point.
// Reset returns the parser to idle with nothing gathered and the output empty.
module terminal_char_tokenizer_top
  import ctt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] token_value,
  output logic [3:0]  token_bytes,
  output logic [1:0]  display_width
);

  state_t st;
  state_t st_next;
  logic   emit;
  token_t tok;
  logic   accept;
  logic   buf_free;

  assign in_ready = buf_free;
  assign accept   = in_valid && buf_free;

  ctt_step u_step (
    .st      (st),
    .in_byte (in_byte),
    .st_next (st_next),
    .emit    (emit),
    .tok     (tok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_IDLE;
    end else if (accept) begin
      st <= st_next;
    end
  end

  ctt_out_buf u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (accept && emit),
    .tok           (tok),
    .buf_free      (buf_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .token_value   (token_value),
    .token_bytes   (token_bytes),
    .display_width (display_width)
  );

endmodule

/* sim/tb.sv */
// Testbench for the terminal byte tokenizer: byte stimulus, token prediction, result checks.
`timescale 1ns / 1ps

module tb;
  import ctt_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_BYTES  = 1300;
  localparam int CHUNK_BYTES   = 300;
  localparam int OPENING_LEN   = 31;

  // idle/delete/ascii/stray bytes, utf8 and kana edges, truncation, esc forms, short csi
  localparam logic [8*OPENING_LEN-1:0] OPENING = {
    8'h00, 8'h7F, 8'h41, 8'h80, 8'hFF,
    8'hC3, 8'hA9,
    8'hEF, 8'hBD, 8'hB1,
    8'hEF, 8'hBE, 8'h9F,
    8'hE3, 8'h00,
    8'h1B, 8'h1A,
    8'h1B, 8'hFF,
    8'h1B, 8'h00,
    8'h1B, 8'h5B, 8'h33, 8'h30, 8'h30, 8'h3B, 8'h3B, 8'h2D, 8'h35, 8'h6D
  };

  typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

  class token_scoreboard;
    mode_t       cur_mode;
    logic [63:0] gathered;
    logic [3:0]  n_gathered;
    logic [2:0]  cont_left;
    logic [7:0]  arg_val;
    logic [2:0]  arg_len;
    logic        arg_done;
    token_t      expected_tokens[$];
    int          errors;
    int          checked;
    int          esc_seen;

    function new();
      go_idle();
    endfunction

    function void clear_arg();
      arg_val  = '0;
      arg_len  = '0;
      arg_done = 1'b0;
    endfunction

    function void go_idle();
      cur_mode   = MODE_IDLE;
      gathered   = '0;
      n_gathered = '0;
      cont_left  = '0;
      clear_arg();
    endfunction

    function void append(logic [7:0] b);
      if (n_gathered < MAX_TOKEN_BYTES) begin
        gathered[8*n_gathered +: 8] = b;
        n_gathered++;
      end
    endfunction

    function void close_token(logic [63:0] v, logic [3:0] n, logic [1:0] w);
      token_t t;
      t.value  = v;
      t.nbytes = n;
      t.width  = w;
      expected_tokens.push_back(t);
      go_idle();
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    // advance the tokenizer by one accepted byte
    function void note_byte(logic [7:0] b);
      logic [23:0] in_order;
      logic [1:0]  cols;
      logic        alpha;
      alpha = (b >= CH_LC_A && b <= CH_LC_Z) || (b >= CH_UC_A && b <= CH_UC_Z);
      case (cur_mode)
        MODE_IDLE: begin
          if (b == CH_ESC) begin
            gathered   = 64'(CH_ESC);
            n_gathered = 4'd1;
            cur_mode   = MODE_ESC;
          end else if (b != CH_NUL && b != CH_DEL) begin
            casez (b)
              8'b110?????: cont_left = 3'd1;
              8'b1110????: cont_left = 3'd2;
              8'b11110???: cont_left = 3'd3;
              default:     cont_left = 3'd0;
            endcase
            if (cont_left == 0) begin
              close_token(64'(b), 4'd1, 2'd1);
            end else begin
              gathered   = 64'(b);
              n_gathered = 4'd1;
              cur_mode   = MODE_UTF8;
            end
          end
        end
        MODE_UTF8: begin
          if (b != CH_NUL) begin
            append(b);
            cont_left--;
          end
          if (b == CH_NUL || cont_left == 0) begin
            in_order = {gathered[7:0], gathered[15:8], gathered[23:16]};
            if (n_gathered <= 1)
              cols = 2'd1;
            else if (n_gathered == 3 && in_order >= HW_KANA_LO && in_order <= HW_KANA_HI)
              cols = 2'd1;
            else
              cols = 2'd2;
            close_token(gathered, n_gathered, cols);
          end
        end
        MODE_ESC: begin
          if (b == CH_NUL || b == CH_SUB || b == CH_FF) begin
            close_token(64'(CH_ESC), 4'd1, 2'd0);
          end else if (b == CH_LBRACK) begin
            gathered   = 64'({CH_LBRACK, CH_ESC});
            n_gathered = 4'd2;
            clear_arg();
            cur_mode   = MODE_CSI;
          end else begin
            close_token(64'({b, CH_ESC}), 4'd2, 2'd0);
          end
        end
        default: begin
          if (b == CH_NUL) begin
            close_token(gathered, n_gathered, 2'd0);
          end else if (b == CH_SEMI || alpha) begin
            if (arg_len > 0) append(arg_val);
            clear_arg();
            if (alpha) begin
              append(b);
              close_token(gathered, n_gathered, 2'd0);
            end else if (n_gathered >= MAX_TOKEN_BYTES) begin
              close_token(gathered, n_gathered, 2'd0);
            end
          end else if (arg_len < PARAM_BUFFER_CHARS) begin
            arg_len++;
            if (!arg_done && b >= CH_ZERO && b <= CH_NINE)
              arg_val = 8'(arg_val * 8'd10 + (b - CH_ZERO));
            else
              arg_done = 1'b1;
          end
        end
      endcase
    endfunction

    task report(string msg);
      if (errors < 40) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_token(logic [63:0] value, logic [3:0] nbytes, logic [1:0] width);
      token_t want;
      if (expected_tokens.size() == 0) begin
        report($sformatf("token %h/%0d/%0d with nothing expected", value, nbytes, width));
        return;
      end
      want = expected_tokens.pop_front();
      checked++;
      if (want.width == 0) esc_seen++;
      if (value !== want.value)
        report($sformatf("token_value %h, wanted %h", value, want.value));
      if (nbytes !== want.nbytes)
        report($sformatf("token_bytes %0d, wanted %0d (value %h)", nbytes, want.nbytes,
                         want.value));
      if (width !== want.width)
        report($sformatf("display_width %0d, wanted %0d (value %h)", width, want.width,
                         want.value));
    endtask

    task flag_leftovers();
      if (expected_tokens.size() != 0)
        report($sformatf("%0d tokens never came out", expected_tokens.size()));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] token_value;
  logic [3:0]  token_bytes;
  logic [1:0]  display_width;

  token_scoreboard sb;
  logic [7:0]      stream[$];
  int              cycles;
  rx_pattern_t     rx_pattern = RX_OPEN;
  int              rx_left;

  terminal_char_tokenizer_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_value  (token_value),
    .token_bytes  (token_bytes),
    .display_width(display_width)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // results first: a byte taken at this edge cannot produce a token until the next one
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_token(token_value, token_bytes, display_width);
      if (in_valid && in_ready) sb.note_byte(in_byte);
    end
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
      rx_left    <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_pattern)
      RX_OPEN:   out_ready <= 1'b1;
      RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
      default:   out_ready <= ((cycles % 7) < 3);
    endcase
  end

  task automatic gen_token();
    int kind;
    int sz;
    int nparams;
    int plen;
    int r;
    kind = $urandom_range(0, 99);
    if (kind < 18) begin
      stream.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end else if (kind < 30) begin
      stream.push_back(8'($urandom_range(8'hC0, 8'hDF)));
      stream.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end else if (kind < 42) begin
      if ($urandom_range(0, 1) == 0) begin
        // around the halfwidth kana window
        stream.push_back(8'hEF);
        stream.push_back(8'($urandom_range(8'hBC, 8'hBF)));
        case ($urandom_range(0, 4))
          0:       stream.push_back(8'hB0);
          1:       stream.push_back(8'hB1);
          2:       stream.push_back(8'h9F);
          3:       stream.push_back(8'hA0);
          default: stream.push_back(8'($urandom_range(8'h01, 8'hFF)));
        endcase
      end else begin
        stream.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        stream.push_back(8'($urandom_range(8'h80, 8'hBF)));
        stream.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
    end else if (kind < 50) begin
      stream.push_back(8'($urandom_range(8'hF0, 8'hF7)));
      repeat (3) stream.push_back(8'($urandom_range(8'h01, 8'hFF)));
    end else if (kind < 55) begin
      // character cut short by end of text
      r  = $urandom_range(0, 2);
      sz = r + 2;
      stream.push_back(r == 0 ? 8'($urandom_range(8'hC0, 8'hDF)) :
                       r == 1 ? 8'($urandom_range(8'hE0, 8'hEF)) :
                                8'($urandom_range(8'hF0, 8'hF7)));
      repeat ($urandom_range(0, sz - 2)) stream.push_back(8'($urandom_range(8'h80, 8'hBF)));
      stream.push_back(CH_NUL);
    end else if (kind < 60) begin
      stream.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                            : 8'($urandom_range(8'hF8, 8'hFF)));
    end else if (kind < 68) begin
      stream.push_back(CH_ESC);
      case ($urandom_range(0, 5))
        0:       stream.push_back(CH_SUB);
        1:       stream.push_back(CH_FF);
        2:       stream.push_back(CH_NUL);
        3:       stream.push_back(CH_ESC);
        default: stream.push_back(8'($urandom_range(8'h01, 8'hFF)));
      endcase
    end else if (kind < 92) begin
      // enough parameters to run into the token length limit
      stream.push_back(CH_ESC);
      stream.push_back(CH_LBRACK);
      nparams = $urandom_range(0, 8);
      for (int p = 0; p < nparams; p++) begin
        plen = $urandom_range(0, 9);
        repeat (plen) begin
          r = $urandom_range(0, 9);
          if (r < 7)
            stream.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
          else if (r < 9)
            stream.push_back(8'($urandom_range(8'h20, 8'h2F)));
          else
            stream.push_back(8'($urandom_range(8'h80, 8'hFF)));
        end
        if (p < nparams - 1) stream.push_back(CH_SEMI);
      end
      r = $urandom_range(0, 19);
      if (r < 17)
        stream.push_back($urandom_range(0, 1) ? 8'($urandom_range(CH_LC_A, CH_LC_Z))
                                              : 8'($urandom_range(CH_UC_A, CH_UC_Z)));
      else if (r < 19)
        stream.push_back(CH_NUL);
    end else if (kind < 96) begin
      stream.push_back($urandom_range(0, 1) ? CH_NUL : CH_DEL);
    end else begin
      stream.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_range(int lo, int hi);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int i = lo; i < hi; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      in_valid <= 1'b1;
      in_byte  <= stream[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
      burst_left--;
    end
  endtask

  // hold the sender until every predicted token has been seen
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int base;
    int hi;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_byte   = '0;
    sb = new();
    for (int i = 0; i < OPENING_LEN; i++)
      stream.push_back(OPENING[8*(OPENING_LEN-1-i) +: 8]);
    while (stream.size() < OPENING_LEN + RANDOM_BYTES) gen_token();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_range(0, OPENING_LEN);
    settle();
    base = OPENING_LEN;
    while (base < stream.size()) begin
      hi = (base + CHUNK_BYTES < stream.size()) ? base + CHUNK_BYTES : stream.size();
      send_range(base, hi);
      settle();
      base = hi;
    end
    sb.flag_leftovers();

    $display("Fed %0d bytes (utf8, kana edges, esc, csi, truncation, noise) in %0d cycles",
             stream.size(), cycles);
    $display("Checked %0d tokens, %0d of them escape or csi", sb.checked, sb.esc_seen);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
